/* hw/rtl/ppba_pkg.sv */
package ppba_pkg;

   localparam int NUM_PAGES_DEFAULT = 32;

   localparam int WORD_BITS  = 64;
   localparam int WORD_IDX_W = 6;
   localparam int SCAN_BITS  = 2 * WORD_BITS;
   localparam int SCAN_IDX_W = WORD_IDX_W + 2;

   localparam int CMD_W      = 2;
   localparam int COUNT_W    = 6;
   localparam int PAGE_IDX_W = 5;
   localparam int PAGE_NUM_W = 5;

   localparam logic [CMD_W-1:0] CMD_ALLOC_ONE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ALLOC_RUN = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FREE      = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_WR_CUR,
      ST_WR_PREV,
      ST_FREE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                  found;
      logic [WORD_IDX_W-1:0] end_pos;
   } find_result_type;

endpackage

/* hw/rtl/ppba_ram.sv */
module ppba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/ppba_run_finder.sv */
module ppba_run_finder (
   input  logic [ppba_pkg::SCAN_BITS-1:0] free_vec,
   input  logic [ppba_pkg::COUNT_W-1:0]   run_len,
   output ppba_pkg::find_result_type      result
);

   logic [ppba_pkg::SCAN_BITS-1:0]  win;
   logic [ppba_pkg::SCAN_BITS-1:0]  pow;
   logic [ppba_pkg::WORD_BITS-1:0]  hits;
   logic [ppba_pkg::WORD_IDX_W-1:0] pos;

   // win[j]: every bit of the run_len window ending at j is free
   always_comb begin
      win = '1;
      pow = free_vec;
      for (int b = 0; b < ppba_pkg::COUNT_W; b++) begin
         if (run_len[b]) begin
            win = pow & (win << (1 << b));
         end
         pow = pow & (pow << (1 << b));
      end
      hits = win[ppba_pkg::SCAN_BITS-1:ppba_pkg::WORD_BITS];
      pos  = '0;
      for (int i = ppba_pkg::WORD_BITS - 1; i >= 0; i--) begin
         if (hits[i]) begin
            pos = ppba_pkg::WORD_IDX_W'(i);
         end
      end
      result.found   = |hits;
      result.end_pos = pos;
   end

endmodule

/* hw/rtl/physical_page_bitmap_allocator.sv */
// First-fit page allocator over a used-bit map held in a one-port-read, one-port-write RAM of
// 64-bit words, ceil(NUM_PAGES/64) deep; pages read as free after reset with no clearing pass.
// One request is in flight at a time. An allocate (one page, or a run of page_count pages,
// which may straddle two words) scans the map one word per cycle from page 0, then writes the
// word with the end of the run and, when the run straddles a word boundary, the word before
// it; if nothing fits, the scan stops at the last word. A free reads the page's word and
// writes it back with that bit cleared; a rejected request goes straight to its result. The
// next request is taken while a result still waits on rsp_.
module physical_page_bitmap_allocator #(
   parameter int NUM_PAGES = ppba_pkg::NUM_PAGES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ppba_pkg::CMD_W-1:0]        req_cmd,
   input  logic [ppba_pkg::COUNT_W-1:0]      req_page_count,
   input  logic [ppba_pkg::PAGE_IDX_W-1:0]   req_page_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_ok,
   output logic [ppba_pkg::PAGE_NUM_W-1:0]   rsp_page_number
);

   localparam int WB        = ppba_pkg::WORD_BITS;
   localparam int NUM_WORDS = (NUM_PAGES + WB - 1) / WB;
   localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int PW        = WADDR_W + ppba_pkg::WORD_IDX_W;
   localparam logic [PW:0]        NUM_PAGES_W = (PW + 1)'(NUM_PAGES);
   localparam logic [WADDR_W-1:0] LAST_WORD   = WADDR_W'(NUM_WORDS - 1);

   ppba_pkg::state_type state_ff, state_in;

   logic [ppba_pkg::CMD_W-1:0]      cmd_ff;
   logic [ppba_pkg::COUNT_W-1:0]    count_ff;
   logic [ppba_pkg::PAGE_IDX_W-1:0] index_ff;
   logic [ppba_pkg::COUNT_W-1:0]    run_len_ff, run_len_in;
   logic [WADDR_W-1:0]              waddr_ff, waddr_in;
   logic [WB-1:0]                   prev_free_ff, prev_free_in;
   logic [WB-1:0]                   prev_used_ff, prev_used_in;
   logic [WB-1:0]                   cur_used_ff, cur_used_in;
   logic [ppba_pkg::WORD_IDX_W-1:0] end_ff, end_in;
   logic                            res_ok_ff, res_ok_in;
   logic [ppba_pkg::PAGE_NUM_W-1:0] res_page_ff, res_page_in;
   logic                            rsp_valid_ff;
   logic                            rsp_ok_ff;
   logic [ppba_pkg::PAGE_NUM_W-1:0] rsp_page_ff;
   logic [NUM_WORDS-1:0]            word_valid_ff;
   logic                            rd_valid_ff;

   logic                            mem_wr_en;
   logic [WADDR_W-1:0]              mem_wr_addr;
   logic [WB-1:0]                   mem_wr_data;
   logic                            mem_rd_en;
   logic [WB-1:0]                   mem_rd_data;

   logic [WB-1:0]                   rd_used;
   logic [WB-1:0]                   beyond;
   logic [WB-1:0]                   cur_free;
   logic [PW-1:0]                   page_addr;
   logic [PW-1:0]                   free_addr;
   logic [ppba_pkg::SCAN_BITS-1:0]  run_mask;
   logic [ppba_pkg::SCAN_IDX_W-1:0] run_hi;
   logic [ppba_pkg::SCAN_IDX_W-1:0] run_lo;
   logic                            req_fire;
   logic                            rsp_slot;
   ppba_pkg::find_result_type       find;

   ppba_ram #(
      .WIDTH (WB),
      .DEPTH (NUM_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (waddr_in),
      .rd_data (mem_rd_data)
   );

   ppba_run_finder u_finder (
      .free_vec ({cur_free, prev_free_ff}),
      .run_len  (run_len_ff),
      .result   (find)
   );

   assign req_ready = (state_ff == ppba_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_slot  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_page_number = rsp_page_ff;

   assign rd_used   = mem_rd_data & {WB{rd_valid_ff}};
   assign free_addr = PW'(index_ff);

   always_comb begin
      for (int i = 0; i < WB; i++) begin
         page_addr = {waddr_ff, ppba_pkg::WORD_IDX_W'(i)};
         beyond[i] = ({1'b0, page_addr} >= NUM_PAGES_W);
      end
      cur_free = ~(rd_used | beyond);
   end

   always_comb begin
      run_hi = {2'b01, end_ff};
      run_lo = run_hi + ppba_pkg::SCAN_IDX_W'(1) - ppba_pkg::SCAN_IDX_W'(run_len_ff);
      for (int j = 0; j < ppba_pkg::SCAN_BITS; j++) begin
         run_mask[j] = (ppba_pkg::SCAN_IDX_W'(j) >= run_lo) &&
                       (ppba_pkg::SCAN_IDX_W'(j) <= run_hi);
      end
   end

   always_comb begin
      state_in     = state_ff;
      run_len_in   = run_len_ff;
      waddr_in     = waddr_ff;
      prev_free_in = prev_free_ff;
      prev_used_in = prev_used_ff;
      cur_used_in  = cur_used_ff;
      end_in       = end_ff;
      res_ok_in    = res_ok_ff;
      res_page_in  = res_page_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = waddr_ff;
      mem_wr_data  = '0;
      mem_rd_en    = 1'b0;
      case (state_ff)
         ppba_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = ppba_pkg::ST_START;
            end
         end
         ppba_pkg::ST_START: begin
            res_ok_in   = 1'b0;
            res_page_in = '0;
            state_in    = ppba_pkg::ST_DONE;
            case (cmd_ff)
               ppba_pkg::CMD_ALLOC_ONE, ppba_pkg::CMD_ALLOC_RUN: begin
                  run_len_in = (cmd_ff == ppba_pkg::CMD_ALLOC_ONE) ?
                               ppba_pkg::COUNT_W'(1) : count_ff;
                  if (cmd_ff == ppba_pkg::CMD_ALLOC_ONE ||
                      (count_ff != '0 && 32'(count_ff) <= NUM_PAGES)) begin
                     waddr_in     = '0;
                     prev_free_in = '0;
                     prev_used_in = '0;
                     mem_rd_en    = 1'b1;
                     state_in     = ppba_pkg::ST_SCAN;
                  end
               end
               ppba_pkg::CMD_FREE: begin
                  if (32'(index_ff) < NUM_PAGES) begin
                     waddr_in  = free_addr[PW-1:ppba_pkg::WORD_IDX_W];
                     mem_rd_en = 1'b1;
                     state_in  = ppba_pkg::ST_FREE;
                  end
               end
               default: begin
                  state_in = ppba_pkg::ST_DONE;
               end
            endcase
         end
         ppba_pkg::ST_SCAN: begin
            if (find.found) begin
               end_in      = find.end_pos;
               cur_used_in = rd_used;
               state_in    = ppba_pkg::ST_WR_CUR;
            end else if (waddr_ff == LAST_WORD) begin
               state_in = ppba_pkg::ST_DONE;
            end else begin
               prev_free_in = cur_free;
               prev_used_in = rd_used;
               waddr_in     = waddr_ff + WADDR_W'(1);
               mem_rd_en    = 1'b1;
            end
         end
         ppba_pkg::ST_WR_CUR: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = cur_used_ff | run_mask[ppba_pkg::SCAN_BITS-1:WB];
            res_ok_in   = 1'b1;
            res_page_in = run_lo[ppba_pkg::PAGE_NUM_W-1:0];
            state_in    = (|run_mask[WB-1:0]) ? ppba_pkg::ST_WR_PREV : ppba_pkg::ST_DONE;
         end
         ppba_pkg::ST_WR_PREV: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = waddr_ff - WADDR_W'(1);
            mem_wr_data = prev_used_ff | run_mask[WB-1:0];
            state_in    = ppba_pkg::ST_DONE;
         end
         ppba_pkg::ST_FREE: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = rd_used &
                          ~(WB'(1) << free_addr[ppba_pkg::WORD_IDX_W-1:0]);
            res_ok_in   = 1'b1;
            state_in    = ppba_pkg::ST_DONE;
         end
         ppba_pkg::ST_DONE: begin
            if (rsp_slot) begin
               state_in = ppba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ppba_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ppba_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         word_valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (mem_wr_en) begin
            word_valid_ff[mem_wr_addr] <= 1'b1;
         end
         if (state_ff == ppba_pkg::ST_DONE && rsp_slot) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff   <= req_cmd;
         count_ff <= req_page_count;
         index_ff <= req_page_index;
      end
      if (mem_rd_en) begin
         rd_valid_ff <= word_valid_ff[waddr_in];
      end
      if (state_ff == ppba_pkg::ST_DONE && rsp_slot) begin
         rsp_ok_ff   <= res_ok_ff;
         rsp_page_ff <= res_page_ff;
      end
      run_len_ff   <= run_len_in;
      waddr_ff     <= waddr_in;
      prev_free_ff <= prev_free_in;
      prev_used_ff <= prev_used_in;
      cur_used_ff  <= cur_used_in;
      end_ff       <= end_in;
      res_ok_ff    <= res_ok_in;
      res_page_ff  <= res_page_in;
   end

endmodule

/* verif/testbench.sv */
module testbench;

   localparam int NUM_PAGES = 32;
   localparam logic [ppba_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD_CYCLES = 300;

   typedef struct {
      logic                            ok;
      logic [ppba_pkg::PAGE_NUM_W-1:0] page;
   } grant_type;

   class scoreboard_type;
      bit [NUM_PAGES-1:0] used_map;
      grant_type pending_grants[$];
      int failures;
      int n_alloc_one;
      int n_alloc_run;
      int n_free;
      int n_unused;
      int n_refused;
      int n_checked;

      function new();
         used_map = '0;
         failures = 0;
         n_alloc_one = 0;
         n_alloc_run = 0;
         n_free = 0;
         n_unused = 0;
         n_refused = 0;
         n_checked = 0;
      endfunction

      function grant_type predict_grant(logic [ppba_pkg::CMD_W-1:0] cmd,
                                        logic [ppba_pkg::COUNT_W-1:0] count,
                                        logic [ppba_pkg::PAGE_IDX_W-1:0] index);
         grant_type g;
         bit [63:0] mask;
         bit [63:0] window;
         g.ok = 1'b0;
         g.page = '0;
         case (cmd)
            ppba_pkg::CMD_ALLOC_ONE: begin
               n_alloc_one++;
               for (int i = 0; i < NUM_PAGES; i++) begin
                  if (!used_map[i]) begin
                     used_map[i] = 1'b1;
                     g.ok = 1'b1;
                     g.page = i[ppba_pkg::PAGE_NUM_W-1:0];
                     break;
                  end
               end
            end
            ppba_pkg::CMD_ALLOC_RUN: begin
               n_alloc_run++;
               if (count != 0 && count <= NUM_PAGES) begin
                  mask = (64'd1 << count) - 64'd1;
                  for (int s = 0; s + count <= NUM_PAGES; s++) begin
                     window = {32'b0, used_map} >> s;
                     if ((window & mask) == 0) begin
                        used_map = used_map | NUM_PAGES'(mask << s);
                        g.ok = 1'b1;
                        g.page = s[ppba_pkg::PAGE_NUM_W-1:0];
                        break;
                     end
                  end
               end
            end
            ppba_pkg::CMD_FREE: begin
               n_free++;
               if (index < NUM_PAGES) begin
                  used_map[index] = 1'b0;
                  g.ok = 1'b1;
               end
            end
            default: n_unused++;
         endcase
         if (!g.ok) n_refused++;
         return g;
      endfunction

      function void note_request(logic [ppba_pkg::CMD_W-1:0] cmd,
                                 logic [ppba_pkg::COUNT_W-1:0] count,
                                 logic [ppba_pkg::PAGE_IDX_W-1:0] index);
         pending_grants.push_back(predict_grant(cmd, count, index));
      endfunction

      function void check_grant(logic ok, logic [ppba_pkg::PAGE_NUM_W-1:0] page);
         grant_type want;
         if (pending_grants.size() == 0) begin
            $display("%0t: unexpected result ok=%0b page=%0d", $time, ok, page);
            failures++;
            return;
         end
         want = pending_grants.pop_front();
         n_checked++;
         if (ok !== want.ok) begin
            $display("%0t: ok mismatch, expected %0b, actual %0b", $time, want.ok, ok);
            failures++;
         end
         if (page !== want.page) begin
            $display("%0t: page_number mismatch, expected %0d, actual %0d",
                     $time, want.page, page);
            failures++;
         end
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic [ppba_pkg::CMD_W-1:0]      req_cmd;
   logic [ppba_pkg::COUNT_W-1:0]    req_page_count;
   logic [ppba_pkg::PAGE_IDX_W-1:0] req_page_index;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic                            rsp_ok;
   logic [ppba_pkg::PAGE_NUM_W-1:0] rsp_page_number;

   scoreboard_type board = new();
   bit sender_gaps;
   bit sink_gaps;
   int long_hold_requests = 0;
   int cycle_count = 0;

   physical_page_bitmap_allocator #(.NUM_PAGES(NUM_PAGES)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_page_count(req_page_count),
      .req_page_index(req_page_index),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_ok(rsp_ok),
      .rsp_page_number(rsp_page_number)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // sample handshakes away from the active edge
   always @(negedge clock) begin
      if (!reset && req_valid && req_ready)
         board.note_request(req_cmd, req_page_count, req_page_index);
      if (!reset && rsp_valid && rsp_ready)
         board.check_grant(rsp_ok, rsp_page_number);
   end

   initial begin : result_sink
      int stall_left;
      int hold_left;
      int holds_seen;
      stall_left = 0;
      hold_left = 0;
      holds_seen = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_requests != holds_seen) begin
            holds_seen = long_hold_requests;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!reset && sink_gaps && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_word(input logic [ppba_pkg::CMD_W-1:0] cmd,
                            input logic [ppba_pkg::COUNT_W-1:0] count,
                            input logic [ppba_pkg::PAGE_IDX_W-1:0] index);
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_page_count <= count;
      req_page_index <= index;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic idle_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending_grants.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_word();
      logic [ppba_pkg::CMD_W-1:0]      cmd;
      logic [ppba_pkg::COUNT_W-1:0]    count;
      logic [ppba_pkg::PAGE_IDX_W-1:0] index;
      int used;
      int free_weight;
      int r;
      used = $countones(board.used_map);
      free_weight = (used > 24) ? 55 : ((used < 8) ? 15 : 35);
      r = $urandom_range(0, 99);
      if (r < 4)
         cmd = CMD_UNUSED;
      else if (r < 4 + free_weight)
         cmd = ppba_pkg::CMD_FREE;
      else if (r < 4 + free_weight + (96 - free_weight) / 2)
         cmd = ppba_pkg::CMD_ALLOC_ONE;
      else
         cmd = ppba_pkg::CMD_ALLOC_RUN;
      r = $urandom_range(0, 9);
      if (r < 8)
         count = ppba_pkg::COUNT_W'($urandom_range(1, 8));
      else if (r < 9)
         count = ppba_pkg::COUNT_W'($urandom_range(9, 32));
      else
         count = ppba_pkg::COUNT_W'($urandom_range(0, 63));
      index = ppba_pkg::PAGE_IDX_W'($urandom_range(0, NUM_PAGES - 1));
      if (cmd == ppba_pkg::CMD_FREE && board.used_map != 0 && $urandom_range(0, 3) != 0) begin
         while (!board.used_map[index]) index = index + 1'b1;
      end
      send_word(cmd, count, index);
   endtask

   task automatic run_random(input int items, input bit allow_gaps);
      for (int n = 0; n < items; n++) begin
         if (n % 50 == 0) begin
            sender_gaps = allow_gaps && $urandom_range(0, 2) != 0;
            sink_gaps = allow_gaps && $urandom_range(0, 2) != 0;
         end
         send_random_word();
         if (sender_gaps && $urandom_range(0, 4) == 0)
            idle_sender($urandom_range(1, 15));
      end
   endtask

   initial begin
      sender_gaps = 1'b0;
      sink_gaps = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_cmd <= ppba_pkg::CMD_ALLOC_ONE;
      req_page_count <= '0;
      req_page_index <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(ppba_pkg::CMD_ALLOC_ONE, 6'd0, 5'd0);
      send_word(ppba_pkg::CMD_ALLOC_RUN, 6'd0, 5'd0);
      send_word(ppba_pkg::CMD_ALLOC_RUN, 6'd63, 5'd31);
      send_word(ppba_pkg::CMD_ALLOC_RUN, 6'd33, 5'd0);
      send_word(ppba_pkg::CMD_ALLOC_RUN, 6'd32, 5'd0);
      send_word(ppba_pkg::CMD_FREE, 6'd0, 5'd0);
      send_word(ppba_pkg::CMD_ALLOC_RUN, 6'd32, 5'd0);
      send_word(ppba_pkg::CMD_ALLOC_ONE, 6'd0, 5'd0);
      send_word(ppba_pkg::CMD_ALLOC_RUN, 6'd1, 5'd0);
      send_word(ppba_pkg::CMD_FREE, 6'd63, 5'd31);
      send_word(ppba_pkg::CMD_ALLOC_RUN, 6'd1, 5'd0);
      send_word(ppba_pkg::CMD_FREE, 6'd0, 5'd0);
      send_word(ppba_pkg::CMD_FREE, 6'd0, 5'd0);
      send_word(CMD_UNUSED, 6'd63, 5'd31);
      send_word(ppba_pkg::CMD_ALLOC_ONE, 6'd0, 5'd0);
      send_word(ppba_pkg::CMD_FREE, 6'd0, 5'd5);
      send_word(ppba_pkg::CMD_FREE, 6'd0, 5'd6);
      send_word(ppba_pkg::CMD_FREE, 6'd0, 5'd7);
      send_word(ppba_pkg::CMD_ALLOC_RUN, 6'd3, 5'd0);
      send_word(ppba_pkg::CMD_FREE, 6'd0, 5'd30);
      send_word(ppba_pkg::CMD_FREE, 6'd0, 5'd31);
      send_word(ppba_pkg::CMD_ALLOC_RUN, 6'd2, 5'd0);
      send_word(ppba_pkg::CMD_ALLOC_ONE, 6'd0, 5'd0);
      wait_drained();

      run_random(700, 1'b1);

      // stall the sink long enough for the block to back up
      sink_gaps = 1'b0;
      long_hold_requests++;
      for (int n = 0; n < 40; n++) send_random_word();
      wait_drained();

      run_random(750, 1'b1);
      wait_drained();
      run_random(250, 1'b0);

      wait_drained();
      repeat (20) @(posedge clock);
      $display("covered %0d single and %0d run allocations, %0d frees, %0d unused codes",
               board.n_alloc_one, board.n_alloc_run, board.n_free, board.n_unused);
      $display("%0d results checked, %0d requests refused", board.n_checked, board.n_refused);
      if (board.failures == 0 && board.pending_grants.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

/* sim.f */
hw/rtl/ppba_pkg.sv
hw/rtl/ppba_ram.sv
hw/rtl/ppba_run_finder.sv
hw/rtl/physical_page_bitmap_allocator.sv
verif/testbench.sv
